@@ rtl/asmc_pkg.sv @@
// ----------------------------------------------------------------------------
// asmc_pkg
// Shared types, constants and saturation helpers of the adaptive sliding-mode axis controller.
// ----------------------------------------------------------------------------
`default_nettype none
package asmc_pkg;
    localparam int unsigned AXES_DEF = 3;
    localparam int unsigned REG_CNT  = 7;
    localparam int unsigned ADDR_W   = 6;

    localparam logic [47:0] GAIN_FLOOR_RST = 48'd1761057376051;
    localparam logic [47:0] ADAPT_RATE_RST = 48'd4398167295795;
    localparam logic [47:0] LIN_GAIN_RST   = 48'd8796106457293;
    localparam logic [47:0] SLOPE_RST      = 48'd17592253154304;
    localparam logic [47:0] DEAD_BAND_RST  = 48'd1760963461530;
    localparam logic [15:0] MASS_RST       = 16'd512;
    localparam logic [31:0] G_Q16          = 32'd642908;
    localparam logic signed [63:0] BR_LIM  = 64'sd1 <<< 40;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        R_GAIN_FLOOR = 3'd0,
        R_ADAPT_RATE = 3'd1,
        R_LIN_GAIN   = 3'd2,
        R_SLOPE      = 3'd3,
        R_DEAD_BAND  = 3'd4,
        R_MASS       = 3'd5,
        R_FF_EN      = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_SIGMA, S_RATE, S_DIV, S_GAIN, S_SQRT, S_KTERM,
        S_K2, S_LEV, S_FORCE, S_LIMIT, S_GRAV, S_OUT
    } t_state;

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic logic signed [63:0] clampv(input logic signed [63:0] v,
                                                  input logic signed [63:0] lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction
endpackage
`default_nettype wire

@@ rtl/adaptive_sliding_mode_axis_control.sv @@
// ----------------------------------------------------------------------------
// adaptive_sliding_mode_axis_control
// Per-axis adaptive super-twisting sliding-mode force controller.
// ----------------------------------------------------------------------------
// One word per control tick. The block computes the sliding surface, adapts the
// axis gain and forms a saturated force under a sequencer. The surface, k2 and
// lambda products share one 33x17 multiplier. From accept to result a word passes
// through these steps:
//   - one step each for the surface, the gain rate, the divide by 40 (reciprocal
//     multiply) and the gain update
//   - the square root, one result bit per step
//   - seven single steps for the root term, the k2 and lambda terms, the mass
//     multiply, the limit, gravity and the output register
// An out-of-range axis skips from the surface step to the output register. o_stall
// is high while a word is in work and while a result waits. A new word is accepted
// at the earliest at the edge where the result of the last word is taken.
`default_nettype none
module adaptive_sliding_mode_axis_control #(
    parameter int unsigned AXES = asmc_pkg::AXES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [asmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]               pwdata,
    output logic      [63:0]               prdata,
    output logic                           pready,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [1:0]                i_axis,
    input  wire logic signed [31:0]        i_target_position,
    input  wire logic signed [31:0]        i_measured_position,
    input  wire logic signed [31:0]        i_target_velocity,
    input  wire logic signed [31:0]        i_measured_velocity,
    input  wire logic signed [31:0]        i_feedforward_force,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [1:0]                     o_axis_out,
    output logic signed [31:0]             o_force_command,
    output logic signed [31:0]             o_surface_value,
    output logic signed [31:0]             o_adaptive_gain_out
);
    import asmc_pkg::*;

    localparam int unsigned AW = (AXES > 1) ? $clog2(AXES) : 1;

    // floor(v/40) = floor(floor(v/8)/5); the offset keeps the operand positive
    localparam logic signed [63:0] DIV_BIAS  = 64'sd2684354560;
    localparam logic signed [63:0] DIV_QBIAS = 64'sd536870912;
    localparam logic [31:0]        DIV_RECIP = 32'hCCCC_CCCD;

    // configuration
    logic [47:0] r_kmin, r_k1, r_k2, r_lam, r_mu;
    logic [15:0] r_mass;
    logic        r_ffen;
    logic [2:0]  w_ridx;
    logic        w_wr;
    assign w_ridx = paddr[5:3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmin <= GAIN_FLOOR_RST;
            r_k1   <= ADAPT_RATE_RST;
            r_k2   <= LIN_GAIN_RST;
            r_lam  <= SLOPE_RST;
            r_mu   <= DEAD_BAND_RST;
            r_mass <= MASS_RST;
            r_ffen <= 1'b1;
        end else if (w_wr) begin
            unique case (w_ridx)
                R_GAIN_FLOOR: r_kmin <= pwdata[47:0];
                R_ADAPT_RATE: r_k1   <= pwdata[47:0];
                R_LIN_GAIN:   r_k2   <= pwdata[47:0];
                R_SLOPE:      r_lam  <= pwdata[47:0];
                R_DEAD_BAND:  r_mu   <= pwdata[47:0];
                R_MASS:       r_mass <= pwdata[15:0];
                R_FF_EN:      r_ffen <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_ridx)
            R_GAIN_FLOOR: prdata = {16'd0, r_kmin};
            R_ADAPT_RATE: prdata = {16'd0, r_k1};
            R_LIN_GAIN:   prdata = {16'd0, r_k2};
            R_SLOPE:      prdata = {16'd0, r_lam};
            R_DEAD_BAND:  prdata = {16'd0, r_mu};
            R_MASS:       prdata = {48'd0, r_mass};
            R_FF_EN:      prdata = {63'd0, r_ffen};
            default:      prdata = 64'd0;
        endcase
    end

    // per-axis state
    logic signed [31:0] r_gain [AXES];
    logic signed [31:0] r_prate [AXES];

    // datapath registers
    t_state r_st, n_st;
    logic [1:0]  r_axis;
    logic [AW-1:0] w_ai;
    logic signed [63:0] r_e, r_ev, r_ff, r_sig, r_acc, r_rate, r_kn, r_t;
    logic [47:0] r_x;        // sqrt radicand
    logic [24:0] r_root;
    logic [5:0]  r_cnt;
    logic [15:0] r_kmin_a, r_k1_a, r_k2_a, r_lam_a, r_mu_a;
    logic        r_bad;
    logic signed [31:0] r_of, r_os, r_ok;
    logic        r_ov;

    assign w_ai = AW'(r_axis);

    // shared multiplier: 33-bit signed by 17-bit signed
    logic signed [32:0] w_ma;
    logic signed [16:0] w_mb;
    logic signed [49:0] w_mp;
    assign w_mp = w_ma * w_mb;

    always_comb begin
        w_ma = 33'sd0;
        w_mb = 17'sd0;
        unique case (r_st)
            S_SIGMA: begin w_ma = r_e[32:0];   w_mb = {1'b0, r_lam_a}; end
            S_K2:    begin w_ma = r_sig[32:0]; w_mb = {1'b0, r_k2_a}; end
            S_LEV:   begin w_ma = r_ev[32:0];  w_mb = {1'b0, r_lam_a}; end
            default: ;
        endcase
    end

    logic w_acc_in;
    assign w_acc_in = i_valid && !o_stall;
    assign o_stall  = (r_st != S_IDLE) || (r_ov && i_stall);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (w_acc_in) n_st = S_SIGMA;
            S_SIGMA: n_st = r_bad ? S_OUT : S_RATE;
            S_RATE:  n_st = S_DIV;
            S_DIV:   n_st = S_GAIN;
            S_GAIN:  n_st = S_SQRT;
            S_SQRT:  if (r_cnt == 6'd0) n_st = S_KTERM;
            S_KTERM: n_st = S_K2;
            S_K2:    n_st = S_LEV;
            S_LEV:   n_st = S_FORCE;
            S_FORCE: n_st = S_LIMIT;
            S_LIMIT: n_st = S_GRAV;
            S_GRAV:  n_st = S_OUT;
            S_OUT:   n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else          r_st <= n_st;
    end

    // division by 40: shift by 3, then reciprocal multiply by 1/5 on a biased operand
    logic [29:0] r_dq;
    logic [31:0] w_dv_x;
    logic [63:0] w_dv_p;
    assign w_dv_x = 32'((r_acc >>> 3) + DIV_BIAS);
    assign w_dv_p = {32'd0, w_dv_x} * {32'd0, DIV_RECIP};

    logic [49:0] r_sqrem;
    logic [49:0] w_sq_rem2;
    logic [49:0] w_sq_cmp;
    assign w_sq_rem2 = {r_sqrem[47:0], r_x[47:46]};
    assign w_sq_cmp  = {24'd0, r_root[23:0], 2'b01};

    logic signed [63:0] w_mag;
    assign w_mag = r_sig < 0 ? -r_sig : r_sig;

    logic signed [56:0] w_prod_kr;
    assign w_prod_kr = $signed(r_kn[31:0]) * $signed({1'b0, r_root[23:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_gain[i]  <= 32'sd0;
                r_prate[i] <= 32'sd0;
            end
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (w_acc_in) begin
                    r_axis <= i_axis;
                    r_bad  <= (i_axis >= 2'd3) || ({30'd0, i_axis} >= 32'(AXES));
                    r_e    <= 64'(i_target_position) - 64'(i_measured_position);
                    r_ev   <= 64'(i_target_velocity) - 64'(i_measured_velocity);
                    r_ff   <= r_ffen ? 64'(i_feedforward_force) : 64'sd0;
                    r_kmin_a <= r_kmin[16*i_axis +: 16];
                    r_k1_a   <= r_k1[16*i_axis +: 16];
                    r_k2_a   <= r_k2[16*i_axis +: 16];
                    r_lam_a  <= r_lam[16*i_axis +: 16];
                    r_mu_a   <= r_mu[16*i_axis +: 16];
                end
                S_SIGMA: begin
                    r_sig <= sat32(r_ev + (64'(w_mp) >>> 12));
                end
                S_RATE: begin
                    if (64'(r_gain[w_ai]) > $signed({44'd0, r_kmin_a, 4'd0})) begin
                        if (w_mag > $signed({44'd0, r_mu_a, 4'd0}))
                            r_rate <= $signed({44'd0, r_k1_a, 4'd0});
                        else if (w_mag < $signed({44'd0, r_mu_a, 4'd0}))
                            r_rate <= -$signed({44'd0, r_k1_a, 4'd0});
                        else r_rate <= 64'sd0;
                        r_acc <= (w_mag > $signed({44'd0, r_mu_a, 4'd0}) ?
                                  $signed({44'd0, r_k1_a, 4'd0}) :
                                  w_mag < $signed({44'd0, r_mu_a, 4'd0}) ?
                                  -$signed({44'd0, r_k1_a, 4'd0}) : 64'sd0)
                                 + 64'(r_prate[w_ai]);
                    end else begin
                        r_rate <= $signed({44'd0, r_kmin_a, 4'd0});
                        r_acc  <= $signed({44'd0, r_kmin_a, 4'd0}) + 64'(r_prate[w_ai]);
                    end
                end
                S_DIV: begin
                    r_dq <= w_dv_p[63:34];
                end
                S_GAIN: begin
                    r_kn <= sat32(64'(r_gain[w_ai]) +
                                  ($signed({34'd0, r_dq}) - DIV_QBIAS));
                    r_x     <= {w_mag[31:0], 16'd0};
                    r_sqrem <= 50'd0;
                    r_root  <= 25'd0;
                    r_cnt   <= 6'd23;
                end
                S_SQRT: begin
                    if (w_sq_rem2 >= w_sq_cmp) begin
                        r_sqrem <= w_sq_rem2 - w_sq_cmp;
                        r_root  <= {r_root[23:0], 1'b1};
                    end else begin
                        r_sqrem <= w_sq_rem2;
                        r_root  <= {r_root[23:0], 1'b0};
                    end
                    r_x   <= {r_x[45:0], 2'b00};
                    r_cnt <= r_cnt - 6'd1;
                end
                S_KTERM: begin
                    r_gain[w_ai]  <= r_kn[31:0];
                    r_prate[w_ai] <= r_rate[31:0];
                    r_t <= 64'(w_prod_kr >>> 16);
                end
                S_K2: begin
                    r_acc <= (r_sig > 0 ? -r_t : (r_sig < 0 ? r_t : 64'sd0))
                             - (64'(w_mp) >>> 12);
                end
                S_LEV: begin
                    r_acc <= clampv(r_ff - r_acc + (64'(w_mp) >>> 12), BR_LIM);
                end
                S_FORCE: begin
                    // bracket is clamped to +-2^40, so 42 signed bits hold it
                    r_t <= (-(64'($signed(r_acc[41:0]) * $signed({1'b0, r_mass})))) >>> 8;
                end
                S_LIMIT: begin
                    r_t <= clampv(r_axis == 2'd2 ? -r_t : r_t,
                                  $signed({48'd0, r_mass}) *
                                  (r_axis == 2'd2 ? 64'sd256 : 64'sd640));
                end
                S_GRAV: begin
                    r_t <= sat32(r_t + (r_axis == 2'd2 ?
                           ($signed({48'd0, r_mass}) * $signed({32'd0, G_Q16})) >>> 8
                           : 64'sd0));
                end
                S_OUT: begin
                    r_ov <= 1'b1;
                    r_of <= r_bad ? 32'sd0 : r_t[31:0];
                    r_os <= r_bad ? 32'sd0 : r_sig[31:0];
                    r_ok <= r_bad ? 32'sd0 : r_kn[31:0];
                end
                default: ;
            endcase
        end
    end

    assign o_valid             = r_ov;
    assign o_axis_out          = r_axis;
    assign o_force_command     = r_of;
    assign o_surface_value     = r_os;
    assign o_adaptive_gain_out = r_ok;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_after_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_st) == S_OUT) else $error("spurious result");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> r_ov && $stable(r_of)) else $error("result lost");
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adaptive sliding-mode axis controller: random
// and directed control ticks against an in-bench force predictor, with
// register changes between phases and random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import asmc_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYC  = 120;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] pos_ref;
        logic signed [31:0] pos_meas;
        logic signed [31:0] vel_ref;
        logic signed [31:0] vel_meas;
        logic signed [31:0] ff;
    } tick_t;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] force_cmd;
        logic signed [31:0] sigma;
        logic signed [31:0] gain;
    } force_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_axis = '0;
    logic signed [31:0] i_target_position = '0, i_measured_position = '0;
    logic signed [31:0] i_target_velocity = '0, i_measured_velocity = '0;
    logic signed [31:0] i_feedforward_force = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_axis_out;
    logic signed [31:0] o_force_command, o_surface_value, o_adaptive_gain_out;

    adaptive_sliding_mode_axis_control uut (.*);

    always #2 i_clk = ~i_clk;

    // predictor copy of registers and per-axis state
    logic [47:0] kmin_r, k1_r, k2_r, lam_r, mu_r;
    logic [15:0] mass_r;
    logic        ff_en_r;
    logic signed [31:0] gain_st [3];
    logic signed [31:0] rate_st [3];

    tick_t  pending_ticks[$];
    force_t expected_forces[$];
    int     mismatches = 0;
    int     wdog = 0;
    bit     hold_send = 1'b0;

    function automatic longint fdiv(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint lim_to(longint v, longint l);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic longint isqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic force_t predict_force(tick_t t);
        force_t o;
        int a;
        longint e, ev, sg, kmin, k1, k2, lam, mu, kc, rate, kn, mag, q, s;
        longint root, kt, u, ffv, br, m, f, lim;
        o = '0;
        o.axis = t.axis;
        a = int'(t.axis);
        if (a >= 3) return o;
        kmin = longint'(kmin_r[16*a +: 16]) << 4;
        k1   = longint'(k1_r[16*a +: 16]) << 4;
        k2   = longint'(k2_r[16*a +: 16]);
        lam  = longint'(lam_r[16*a +: 16]);
        mu   = longint'(mu_r[16*a +: 16]) << 4;
        m    = longint'(mass_r);
        e  = longint'(t.pos_ref) - longint'(t.pos_meas);
        ev = longint'(t.vel_ref) - longint'(t.vel_meas);
        sg = sat_s32(ev + fdiv(lam * e, 12));
        kc = longint'(gain_st[a]);
        mag = sg < 0 ? -sg : sg;
        if (kc > kmin) rate = (mag > mu) ? k1 : ((mag < mu) ? -k1 : 0);
        else rate = kmin;
        s = rate + longint'(rate_st[a]);
        q = s / 40;
        if ((s % 40) != 0 && s < 0) q--;
        kn = sat_s32(kc + q);
        gain_st[a] = 32'(kn);
        rate_st[a] = 32'(rate);
        root = isqrt(mag << 16);
        kt = fdiv(kn * root, 16);
        u = (sg > 0) ? -kt : ((sg < 0) ? kt : 0);
        u -= fdiv(k2 * sg, 12);
        ffv = ff_en_r ? longint'(t.ff) : 0;
        br = lim_to(ffv - u + fdiv(lam * ev, 12), 64'sd1 << 40);
        f = fdiv(-(m * br), 8);
        if (a == 2) begin
            f = -f;
            lim = m * 256;
        end else begin
            lim = m * 640;
        end
        f = lim_to(f, lim);
        if (a == 2) f += (m * 642908) >>> 8;
        o.force_cmd = 32'(sat_s32(f));
        o.sigma = 32'(sg);
        o.gain = 32'(kn);
        return o;
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_ticks.size() > 0 && !hold_send) begin
                    tick_t t;
                    t = pending_ticks.pop_front();
                    expected_forces.push_back(predict_force(t));
                    {i_axis, i_target_position, i_measured_position, i_target_velocity,
                     i_measured_velocity, i_feedforward_force} <= t;
                    i_valid <= 1'b1;
                    if (burst_left <= 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 60);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern and result check
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= ($urandom_range(0, 9) != 0);
            endcase
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) wdog <= 0;
            else wdog <= wdog + 1;
            if (o_valid && !i_stall) begin
                force_t got, exp_f;
                got = {o_axis_out, o_force_command, o_surface_value, o_adaptive_gain_out};
                if (expected_forces.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", got);
                end else begin
                    exp_f = expected_forces.pop_front();
                    if (got !== exp_f) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp axis %0d f %0d s %0d k %0d, got %0d %0d %0d %0d",
                                exp_f.axis, exp_f.force_cmd, exp_f.sigma, exp_f.gain,
                                got.axis, got.force_cmd, got.sigma, got.gain);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (wdog >= WDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(8 * int'(idx));
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            R_GAIN_FLOOR: kmin_r = val[47:0];
            R_ADAPT_RATE: k1_r = val[47:0];
            R_LIN_GAIN:   k2_r = val[47:0];
            R_SLOPE:      lam_r = val[47:0];
            R_DEAD_BAND:  mu_r = val[47:0];
            R_MASS:       mass_r = val[15:0];
            default:      ff_en_r = val[0];
        endcase
    endtask

    task automatic wait_idle();
        while (pending_ticks.size() > 0 || expected_forces.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd32(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 262143)) - 131072);
            default: return 32'($signed($urandom_range(0, 2047)) - 1024);
        endcase
    endfunction

    task automatic add_tick(logic [1:0] ax, logic [31:0] a, logic [31:0] b,
                            logic [31:0] c, logic [31:0] d, logic [31:0] f);
        tick_t t;
        t = {ax, a, b, c, d, f};
        pending_ticks.push_back(t);
    endtask

    task automatic random_ticks(int n);
        int mode;
        repeat (n) begin
            mode = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
            add_tick(($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                     rnd32(mode), rnd32(mode), rnd32(mode), rnd32(mode), rnd32(mode));
        end
    endtask

    task automatic random_regs();
        write_reg(R_GAIN_FLOOR, {$urandom, $urandom});
        write_reg(R_ADAPT_RATE, {$urandom, $urandom});
        write_reg(R_LIN_GAIN, {$urandom, $urandom});
        write_reg(R_SLOPE, {$urandom, $urandom});
        write_reg(R_DEAD_BAND, {$urandom, $urandom});
        write_reg(R_MASS, {$urandom, $urandom});
        write_reg(R_FF_EN, {$urandom, $urandom});
    endtask

    initial begin
        kmin_r = GAIN_FLOOR_RST;
        k1_r = ADAPT_RATE_RST;
        k2_r = LIN_GAIN_RST;
        lam_r = SLOPE_RST;
        mu_r = DEAD_BAND_RST;
        mass_r = MASS_RST;
        ff_en_r = 1'b1;
        for (int i = 0; i < 3; i++) begin
            gain_st[i] = '0;
            rate_st[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero surface, every axis, out-of-range axis
        add_tick(2'd0, 0, 0, 0, 0, 0);
        add_tick(2'd1, 0, 0, 0, 0, 0);
        add_tick(2'd2, 0, 0, 0, 0, 0);
        add_tick(2'd3, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        add_tick(2'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        add_tick(2'd1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        add_tick(2'd2, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
        add_tick(2'd2, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        add_tick(2'd0, 32'hffffffff, 0, 32'h00010000, 32'hffffffff, 32'hffff0000);
        add_tick(2'd1, 32'h00001000, 32'h00001000, 32'h00000010, 0, 32'h00050000);
        add_tick(2'd2, 32'h00020000, 0, 0, 32'h00010000, 32'hfffb0000);
        add_tick(2'd3, 0, 0, 0, 0, 0);
        wait_idle();

        // extreme register settings: all ones with feedforward off, then all zeros with mass zero
        write_reg(R_GAIN_FLOOR, 64'hffff_ffff_ffff_ffff);
        write_reg(R_ADAPT_RATE, 64'hffff_ffff_ffff_ffff);
        write_reg(R_LIN_GAIN, 64'hffff_ffff_ffff_ffff);
        write_reg(R_SLOPE, 64'hffff_ffff_ffff_ffff);
        write_reg(R_DEAD_BAND, 64'hffff_ffff_ffff_ffff);
        write_reg(R_MASS, 64'hffff);
        write_reg(R_FF_EN, 64'h0);
        random_ticks(60);
        wait_idle();
        write_reg(R_GAIN_FLOOR, 64'h0);
        write_reg(R_ADAPT_RATE, 64'h0);
        write_reg(R_LIN_GAIN, 64'h0);
        write_reg(R_SLOPE, 64'h0);
        write_reg(R_DEAD_BAND, 64'h0);
        write_reg(R_MASS, 64'h0);
        write_reg(R_FF_EN, 64'h1);
        random_ticks(60);
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            random_regs();
            random_ticks(90);
            // sender holds off until the block has drained
            while (pending_ticks.size() > 45) @(posedge i_clk);
            hold_send = 1'b1;
            while (expected_forces.size() > 0) @(posedge i_clk);
            hold_send = 1'b0;
            wait_idle();
        end
        write_reg(R_GAIN_FLOOR, GAIN_FLOOR_RST);
        write_reg(R_ADAPT_RATE, ADAPT_RATE_RST);
        write_reg(R_LIN_GAIN, LIN_GAIN_RST);
        write_reg(R_SLOPE, SLOPE_RST);
        write_reg(R_DEAD_BAND, DEAD_BAND_RST);
        write_reg(R_MASS, MASS_RST);
        write_reg(R_FF_EN, 64'h1);
        random_ticks(470);
        wait_idle();

        if (mismatches == 0 && expected_forces.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
